// ----- rtl/sva_pkg.sv -----
package sva_pkg;

    localparam int CHANNELS_DEF   = 9;
    localparam int STAMP_BITS_DEF = 32;

    localparam logic [1:0] KIND_NOTE_ON   = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF  = 2'd1;
    localparam logic [1:0] KIND_ALL_OFF   = 2'd2;
    localparam logic [1:0] KIND_PATCH_UPD = 2'd3;

    localparam logic [1:0] ACT_PLAY    = 2'd0;
    localparam logic [1:0] ACT_KEY_OFF = 2'd1;
    localparam logic [1:0] ACT_PATCH   = 2'd2;

    localparam logic [3:0] CFG_RESET = 4'd9;

    localparam logic [6:0] TOP_NOTE  = 7'd114;
    localparam logic [6:0] LOW_NOTES = 7'd19;
    localparam logic [6:0] OCTAVE    = 7'd12;

    // Division by twelve is done as a multiply by 43/512, exact for offsets up to 95.
    localparam logic [12:0] RECIP       = 13'd43;
    localparam int          RECIP_SHIFT = 9;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic note_on;
        logic hit;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [2:0] blk;
        logic [4:0] pit;
    } t_pitch;

    function automatic t_pitch note_pitch(input logic [6:0] note);
        logic [6:0]  d;
        logic [12:0] prod;
        logic [2:0]  q;
        logic [6:0]  r;
        t_pitch      p;
        d    = 7'(note - LOW_NOTES);
        prod = 13'(d) * RECIP;
        q    = 3'(prod >> RECIP_SHIFT);
        r    = 7'(d - 7'(7'(q) * OCTAVE));
        if (note < LOW_NOTES) begin
            p.blk = 3'd0;
            p.pit = note[4:0];
        end else begin
            p.blk = q;
            p.pit = 5'(r + LOW_NOTES);
        end
        return p;
    endfunction

endpackage

// ----- rtl/sva_in_if.sv -----
interface sva_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] patch_id;
    logic [6:0] note;

    modport source(output valid, output kind, output patch_id, output note, input ready);
    modport sink(input valid, input kind, input patch_id, input note, output ready);
endinterface

// ----- rtl/sva_out_if.sv -----
interface sva_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] channel;
    logic [1:0] action;
    logic [2:0] octave_block;
    logic [4:0] pitch_index;
    logic       last;

    modport source(output valid, output channel, output action, output octave_block,
                   output pitch_index, output last, input ready);
    modport sink(input valid, input channel, input action, input octave_block,
                 input pitch_index, input last, output ready);
endinterface

// ----- rtl/sva_ctrl.sv -----
module sva_ctrl
    import sva_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [3:0]       i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd,
    output logic [IDX_W-1:0] o_idx
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_NOTE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [3:0]       r_cfg;
    logic [5:0]       w_live;
    logic [IDX_W-1:0] w_last_idx;
    logic             w_at_last;

    always_comb begin
        if (r_cfg == 4'd0) begin
            w_live = 6'd1;
        end else if (6'(r_cfg) > 6'(CHANNELS)) begin
            w_live = 6'(CHANNELS);
        end else begin
            w_live = 6'(r_cfg);
        end
    end

    assign w_last_idx = IDX_W'(w_live - 6'd1);
    assign w_at_last  = (r_idx == w_last_idx);
    assign o_idx      = r_idx;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_idx       = '0;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (w_at_last) begin
                    n_idx   = '0;
                    n_state = i_sts.note_on ? ST_NOTE : ST_EMIT;
                end else begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            ST_NOTE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free || !i_sts.hit) begin
                    o_cmd.emit = 1'b1;
                    if (w_at_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = IDX_W'(r_idx + 1'b1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_cfg   <= CFG_RESET;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

endmodule

// ----- rtl/sva_dp.sv -----
module sva_dp
    import sva_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF,
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_patch_id,
    input  logic [6:0]       i_note,
    output t_dp_sts          o_sts,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [3:0]       o_channel,
    output logic [1:0]       o_action,
    output logic [2:0]       o_octave_block,
    output logic [4:0]       o_pitch_index,
    output logic             o_last
);

    logic [7:0]            r_patch    [CHANNELS];
    logic                  r_assigned [CHANNELS];
    logic [6:0]            r_note     [CHANNELS];
    logic                  r_sounding [CHANNELS];
    logic [STAMP_BITS-1:0] r_stamp    [CHANNELS];

    logic [STAMP_BITS-1:0] r_clock;
    logic [STAMP_BITS-1:0] r_now;
    logic [1:0]            r_kind;
    logic [7:0]            r_pid;
    logic [6:0]            r_key;

    logic                  r_have_off;
    logic                  r_have_on;
    logic [IDX_W-1:0]      r_best_off;
    logic [IDX_W-1:0]      r_best_on;
    logic [STAMP_BITS-1:0] r_age_off;
    logic [STAMP_BITS-1:0] r_age_on;
    logic [CHANNELS-1:0]   r_match;

    logic                  r_out_valid;
    logic [3:0]            r_out_channel;
    logic [1:0]            r_out_action;
    logic [2:0]            r_out_blk;
    logic [4:0]            r_out_pit;
    logic                  r_out_last;

    logic [STAMP_BITS-1:0] w_age;
    logic                  w_hit_match;
    logic [IDX_W-1:0]      w_best;
    logic                  w_out_free;
    logic [CHANNELS-1:0]   w_above;
    logic                  w_more;
    t_pitch                w_pitch;

    assign w_age       = r_now - r_stamp[i_idx];
    assign w_hit_match = r_assigned[i_idx] && (r_patch[i_idx] == r_pid)
                         && ((r_kind != KIND_NOTE_OFF) || (r_note[i_idx] == r_key));
    assign w_best      = r_have_off ? r_best_off : r_best_on;
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_pitch     = note_pitch(r_key);

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            w_above[i] = r_match[i] && (i > int'(i_idx));
        end
    end

    assign w_more = |w_above;

    assign o_sts.note_on  = (r_kind == KIND_NOTE_ON);
    assign o_sts.hit      = r_match[i_idx];
    assign o_sts.out_free = w_out_free;

    assign o_valid        = r_out_valid;
    assign o_channel      = r_out_channel;
    assign o_action       = r_out_action;
    assign o_octave_block = r_out_blk;
    assign o_pitch_index  = r_out_pit;
    assign o_last         = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_patch[i]    <= '0;
                r_assigned[i] <= 1'b0;
                r_note[i]     <= '0;
                r_sounding[i] <= 1'b0;
                r_stamp[i]    <= '0;
            end
            r_clock     <= STAMP_BITS'(1);
            r_have_off  <= 1'b0;
            r_have_on   <= 1'b0;
            r_match     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_kind     <= i_kind;
                r_pid      <= i_patch_id;
                r_key      <= i_note;
                r_now      <= r_clock;
                r_clock    <= r_clock + 1'b1;
                r_have_off <= 1'b0;
                r_have_on  <= 1'b0;
                r_match    <= '0;
            end

            if (i_cmd.scan) begin
                if (r_kind == KIND_NOTE_ON) begin
                    if (r_sounding[i_idx]) begin
                        if (!r_have_on || (w_age > r_age_on)) begin
                            r_have_on <= 1'b1;
                            r_age_on  <= w_age;
                            r_best_on <= i_idx;
                        end
                    end else begin
                        if (!r_have_off || (w_age > r_age_off)) begin
                            r_have_off <= 1'b1;
                            r_age_off  <= w_age;
                            r_best_off <= i_idx;
                        end
                    end
                end else begin
                    r_match[i_idx] <= w_hit_match;
                    if (w_hit_match && (r_kind != KIND_PATCH_UPD)) begin
                        r_stamp[i_idx]    <= r_now;
                        r_sounding[i_idx] <= 1'b0;
                    end
                end
            end

            if (i_cmd.commit) begin
                r_patch[w_best]    <= r_pid;
                r_assigned[w_best] <= 1'b1;
                r_note[w_best]     <= r_key;
                r_sounding[w_best] <= 1'b1;
                r_stamp[w_best]    <= r_now;
                r_out_valid        <= 1'b1;
                r_out_channel      <= 4'(w_best);
                r_out_last         <= 1'b1;
                if (r_key > TOP_NOTE) begin
                    r_out_action <= ACT_KEY_OFF;
                    r_out_blk    <= 3'd0;
                    r_out_pit    <= 5'd0;
                end else begin
                    r_out_action <= ACT_PLAY;
                    r_out_blk    <= w_pitch.blk;
                    r_out_pit    <= w_pitch.pit;
                end
            end else if (i_cmd.emit && r_match[i_idx]) begin
                r_out_valid   <= 1'b1;
                r_out_channel <= 4'(i_idx);
                r_out_action  <= (r_kind == KIND_PATCH_UPD) ? ACT_PATCH : ACT_KEY_OFF;
                r_out_blk     <= 3'd0;
                r_out_pit     <= 5'd0;
                r_out_last    <= !w_more;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/synth_voice_allocator_top.sv -----
// Each input transaction is followed by a scan that reads one channel's state per cycle over
// the N active channels; results are produced after the scan.
// A new input is accepted only once the previous one is fully handled, and a waiting result
// that is not taken holds the allocator.
// Reset is synchronous, active low: all channels off and unassigned, event clock one,
// active channel count nine.
module synth_voice_allocator_top
    import sva_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    sva_in_if.sink     i_in,
    sva_out_if.source  o_out
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [IDX_W-1:0] w_idx;
    logic             w_in_ready;

    assign i_in.ready = w_in_ready;

    sva_ctrl #(
        .CHANNELS(CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    sva_dp #(
        .CHANNELS  (CHANNELS),
        .STAMP_BITS(STAMP_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_idx         (w_idx),
        .i_kind        (i_in.kind),
        .i_patch_id    (i_in.patch_id),
        .i_note        (i_in.note),
        .o_sts         (w_sts),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_channel     (o_out.channel),
        .o_action      (o_out.action),
        .o_octave_block(o_out.octave_block),
        .o_pitch_index (o_out.pitch_index),
        .o_last        (o_out.last)
    );

endmodule
